/* hw/rtl/h2r_pkg.sv */
// Package: widths, constants and payload types of the HSV to RGB converter.
`timescale 1ns / 1ps
package h2r_pkg;

    localparam int unsigned CHAN_W      = 16;
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned HUE_CIRCLE  = 23040;
    localparam int unsigned HUE_SECTOR  = 3840;
    localparam int unsigned HM_W        = $clog2(HUE_CIRCLE);
    localparam int unsigned REM_W       = $clog2(HUE_SECTOR);
    localparam int unsigned RECIP_SHIFT = REM_W;
    localparam int unsigned RECIP_W     = FRAC_BITS + 1;
    localparam longint unsigned RECIP   =
        (64'd1 << (FRAC_BITS + RECIP_SHIFT)) / HUE_SECTOR;
    localparam int unsigned RQ_W        = REM_W + RECIP_W;
    localparam int unsigned NUM_W       = REM_W + FRAC_BITS;
    localparam int unsigned NUM_STAGES  = 6;
    localparam int unsigned NUM_SECTORS = 6;

    typedef enum logic [2:0] {
        SECTOR_RY = 3'd0,
        SECTOR_YG = 3'd1,
        SECTOR_GC = 3'd2,
        SECTOR_CB = 3'd3,
        SECTOR_BM = 3'd4,
        SECTOR_MR = 3'd5
    } sector_t;

    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

/* hw/rtl/h2r_stream_if.sv */
// Interface: valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps
interface h2r_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/hsv_to_rgb_converter.sv */
// Top level: pipelined HSV to RGB color converter.
// Pipeline: an accepted input beat passes through every stage register, stage 0 through the output register.
// Throughput: one beat per cycle while the output drains; each stage has its own valid bit and
// enable in one shared stall chain, so bubbles close up while the output beat waits.
// Reset: rst_n clears all stage valid bits at once; payload registers are not reset.
`timescale 1ns / 1ps
module hsv_to_rgb_converter (
    input  logic         clk,
    input  logic         rst_n,
    h2r_stream_if.sink   hsv,
    h2r_stream_if.source rgb
);
    import h2r_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stage_en;
    logic [NUM_STAGES-1:0] load;

    // stage 0: hue reduced modulo one circle
    logic [HM_W-1:0]      hm_next, hm_reg;
    logic [CHAN_W-1:0]    s0_reg, v0_reg;
    // stage 1: sector and remainder
    sector_t              sec_next, sec1_reg;
    logic [REM_W-1:0]     rem_next, rem1_reg;
    logic [CHAN_W-1:0]    s1_reg, v1_reg;
    // stage 2: reciprocal estimate of the fraction
    logic [RQ_W-1:0]      rq_prod;
    logic [FRAC_BITS-1:0] q0_reg;
    logic [REM_W-1:0]     rem2_reg;
    sector_t              sec2_reg;
    logic [CHAN_W-1:0]    s2_reg, v2_reg;
    // stage 3: corrected fraction
    logic [NUM_W-1:0]     num_w, back_w, res_w;
    logic [FRAC_BITS-1:0] f_next, f_reg;
    sector_t              sec3_reg;
    logic [CHAN_W-1:0]    s3_reg, v3_reg;
    // stage 4: s*f, s*(1-f), p
    logic [FRAC_BITS:0]          onemf;
    logic [CHAN_W+FRAC_BITS-1:0] sf_prod;
    logic [CHAN_W+FRAC_BITS:0]   sg_prod;
    logic [2*CHAN_W:0]           p_prod;
    logic [CHAN_W-1:0]           sf_reg, sg_reg, p_reg, v4_reg;
    sector_t                     sec4_reg;
    // stage 5: q, t and channel select
    logic [2*CHAN_W:0]    q_prod, t_prod;
    logic [CHAN_W-1:0]    q_val, t_val;
    rgb_t                 out_next, out_reg;

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || rgb.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
        vld_next = {vld_reg[NUM_STAGES-2:0], hsv.valid};
        load     = stage_en & vld_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign hsv.ready   = stage_en[0];
    assign rgb.valid   = vld_reg[NUM_STAGES-1];
    assign rgb.payload = out_reg;

    always_comb
    begin
        if (hsv.payload.hue >= CHAN_W'(2 * HUE_CIRCLE))
        begin
            hm_next = HM_W'(hsv.payload.hue - CHAN_W'(2 * HUE_CIRCLE));
        end
        else if (hsv.payload.hue >= CHAN_W'(HUE_CIRCLE))
        begin
            hm_next = HM_W'(hsv.payload.hue - CHAN_W'(HUE_CIRCLE));
        end
        else
        begin
            hm_next = HM_W'(hsv.payload.hue);
        end
    end

    always_comb
    begin
        logic [HM_W-1:0] base;
        base     = '0;
        sec_next = SECTOR_RY;
        for (int k = 1; k < NUM_SECTORS; k++)
        begin
            if (hm_reg >= HM_W'(k * HUE_SECTOR))
            begin
                base     = HM_W'(k * HUE_SECTOR);
                sec_next = sector_t'(3'(k));
            end
        end
        rem_next = REM_W'(hm_reg - base);
    end

    assign rq_prod = RQ_W'(rem1_reg) * RQ_W'(RECIP);

    always_comb
    begin
        num_w  = {rem2_reg, {FRAC_BITS{1'b0}}};
        back_w = NUM_W'(q0_reg) * NUM_W'(HUE_SECTOR);
        res_w  = num_w - back_w;
        f_next = (res_w >= NUM_W'(HUE_SECTOR)) ? q0_reg + 1'b1 : q0_reg;
    end

    always_comb
    begin
        onemf   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
        onemf   = onemf - (FRAC_BITS + 1)'(f_reg);
        sf_prod = (CHAN_W + FRAC_BITS)'(s3_reg) * (CHAN_W + FRAC_BITS)'(f_reg);
        sg_prod = (CHAN_W + FRAC_BITS + 1)'(s3_reg) * (CHAN_W + FRAC_BITS + 1)'(onemf);
        p_prod  = (2 * CHAN_W + 1)'(v3_reg)
                * ((2 * CHAN_W + 1)'(1 << CHAN_W) - (2 * CHAN_W + 1)'(s3_reg));
    end

    always_comb
    begin
        q_prod = (2 * CHAN_W + 1)'(v4_reg)
               * ((2 * CHAN_W + 1)'(1 << CHAN_W) - (2 * CHAN_W + 1)'(sf_reg));
        t_prod = (2 * CHAN_W + 1)'(v4_reg)
               * ((2 * CHAN_W + 1)'(1 << CHAN_W) - (2 * CHAN_W + 1)'(sg_reg));
        q_val  = q_prod[CHAN_W +: CHAN_W];
        t_val  = t_prod[CHAN_W +: CHAN_W];
        unique case (sec4_reg)
            SECTOR_RY: out_next = '{red: v4_reg, green: t_val,  blue: p_reg};
            SECTOR_YG: out_next = '{red: q_val,  green: v4_reg, blue: p_reg};
            SECTOR_GC: out_next = '{red: p_reg,  green: v4_reg, blue: t_val};
            SECTOR_CB: out_next = '{red: p_reg,  green: q_val,  blue: v4_reg};
            SECTOR_BM: out_next = '{red: t_val,  green: p_reg,  blue: v4_reg};
            default:   out_next = '{red: v4_reg, green: p_reg,  blue: q_val};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            hm_reg <= hm_next;
            s0_reg <= hsv.payload.saturation;
            v0_reg <= hsv.payload.brightness;
        end
        if (load[1])
        begin
            sec1_reg <= sec_next;
            rem1_reg <= rem_next;
            s1_reg   <= s0_reg;
            v1_reg   <= v0_reg;
        end
        if (load[2])
        begin
            q0_reg   <= rq_prod[RECIP_SHIFT +: FRAC_BITS];
            rem2_reg <= rem1_reg;
            sec2_reg <= sec1_reg;
            s2_reg   <= s1_reg;
            v2_reg   <= v1_reg;
        end
        if (load[3])
        begin
            f_reg    <= f_next;
            sec3_reg <= sec2_reg;
            s3_reg   <= s2_reg;
            v3_reg   <= v2_reg;
        end
        if (load[4])
        begin
            sf_reg   <= sf_prod[FRAC_BITS +: CHAN_W];
            sg_reg   <= sg_prod[FRAC_BITS +: CHAN_W];
            p_reg    <= p_prod[CHAN_W +: CHAN_W];
            v4_reg   <= v3_reg;
            sec4_reg <= sec3_reg;
        end
        if (load[5])
        begin
            out_reg <= out_next;
        end
    end

endmodule

/* hw/rtl/h2r_checker.sv */
// Checker: port-level assertions for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
module h2r_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input h2r_pkg::rgb_t out_data
);
    import h2r_pkg::*;

    // hold a stalled output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output payload changed while stalled");

    // accept whenever the output side can advance
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (hsv.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out_data  (rgb.payload)
);
